FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the inverse Gaussian transform.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/igt_pkg.sv
// Shared constants and types of the inverse Gaussian transform.
package igt_pkg;

  // Pipeline depths of the root, divider and normalising shift units.
  localparam int SQRT_STAGES  = 32;
  localparam int DIV_STAGES   = 32;
  localparam int SHIFT_STAGES = 5;

  // Configuration register indexes.
  localparam logic [7:0] CFG_MEAN  = 8'd0;
  localparam logic [7:0] CFG_SHAPE = 8'd1;

  // Side information that travels alongside the square root unit.
  typedef struct packed {
    logic [15:0] u;
    logic [30:0] a;
    logic        az;
  } root_side_t;

  // Side information that travels alongside the first divider.
  typedef struct packed {
    logic [15:0] u;
    logic        az;
  } quot_side_t;

  // Side information that travels alongside the reciprocal divider.
  typedef struct packed {
    logic [23:0] x;
    logic        pass;
    logic        ovf;
    logic        xzero;
  } recip_side_t;

endpackage

FILE: hw/rtl/igt_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module igt_sqrt import igt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [62:0] radicand,
  output logic        out_valid,
  output logic [31:0] root
);

  logic [SQRT_STAGES:1] vld_r;
  logic [63:0]          rem_r [1:SQRT_STAGES];
  logic [63:0]          acc_r [1:SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STAGES - 1 - j));
    logic [63:0] rem_in;
    logic [63:0] acc_in;
    logic [63:0] trial;
    logic        vin;

    if (j == 0) begin : g_first
      assign rem_in = {1'b0, radicand};
      assign acc_in = '0;
      assign vin    = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[j];
      assign acc_in = acc_r[j];
      assign vin    = vld_r[j];
    end

    assign trial = acc_in + BIT;

    // Valid bit of this stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vin;
      end
    end

    // One restoring step: subtract the trial value when it fits.
    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_r[j+1] <= rem_in - trial;
        acc_r[j+1] <= (acc_in >> 1) + BIT;
      end else begin
        rem_r[j+1] <= rem_in;
        acc_r[j+1] <= acc_in >> 1;
      end
    end
  end

  assign out_valid = vld_r[SQRT_STAGES];
  assign root      = acc_r[SQRT_STAGES][31:0];

endmodule

FILE: hw/rtl/igt_div.sv
// Pipelined restoring divider giving a 32-bit quotient, one bit per stage.
module igt_div import igt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [55:0] num,
  input  logic [32:0] den,
  output logic        out_valid,
  output logic [31:0] quot
);

  logic [DIV_STAGES:1] vld_r;
  logic [55:0]         rem_r [1:DIV_STAGES];
  logic [32:0]         den_r [1:DIV_STAGES];
  logic [31:0]         quo_r [1:DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
    localparam int SH = DIV_STAGES - 1 - j;
    logic [55:0] rem_in;
    logic [32:0] den_in;
    logic [31:0] quo_in;
    logic [63:0] trial;
    logic        vin;

    if (j == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
      assign vin    = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[j];
      assign den_in = den_r[j];
      assign quo_in = quo_r[j];
      assign vin    = vld_r[j];
    end

    assign trial = {31'd0, den_in} << SH;

    // Valid bit of this stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vin;
      end
    end

    // Subtract the shifted divisor where it fits and record the quotient bit.
    always_ff @(posedge clk) begin
      den_r[j+1] <= den_in;
      if ({8'd0, rem_in} >= trial) begin
        rem_r[j+1] <= rem_in - trial[55:0];
        quo_r[j+1] <= quo_in | (32'd1 << SH);
      end else begin
        rem_r[j+1] <= rem_in;
        quo_r[j+1] <= quo_in;
      end
    end
  end

  assign out_valid = vld_r[DIV_STAGES];
  assign quot      = quo_r[DIV_STAGES];

endmodule

FILE: hw/rtl/inverse_gaussian_transform_top.sv
// Top level of the pipelined inverse Gaussian transform.
//
//  channel  direction  handshake              payload
//  in_      in         start high, busy low   in_normal_sample, in_uniform_sample
//  out_     out        out_strobe, one cycle  out_sample, out_took_reciprocal, out_saturated
//  cfg_     in         cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A new word is taken on every cycle that start is high; busy is always low.
// Each result is registered through the 32-stage square root and the two 32-stage
// dividers in line, among the other stages of the pipeline.
// Synchronous active-low reset clears every valid bit and sets mean and
// shape to 1.0. The receiver cannot stall, so nothing is ever held back.
`include "assert_macros.svh"
module inverse_gaussian_transform_top import igt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_normal_sample,
  input  logic [15:0] in_uniform_sample,
  output logic        out_strobe,
  output logic [31:0] out_sample,
  output logic        out_took_reciprocal,
  output logic        out_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [23:0] mean_r;
  logic [23:0] shape_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= 24'd65536;
      shape_r <= 24'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MEAN:  mean_r  <= cfg_data;
        CFG_SHAPE: shape_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front stages: magnitude, square, scale by the mean, larger operand.
  logic        p0_v_r, p1_v_r, p2_v_r;
  logic [15:0] p0_mag_r, p0_u_r, p1_u_r, p2_u_r;
  logic [30:0] p1_y_r;
  logic [54:0] p2_a_r;
  logic [49:0] p2_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p0_v_r <= start && !busy;
      p1_v_r <= p0_v_r;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p0_mag_r <= in_normal_sample[15] ? 16'(~in_normal_sample + 16'd1) : in_normal_sample;
    p0_u_r   <= in_uniform_sample;
    p1_y_r   <= 31'(p0_mag_r * p0_mag_r);
    p1_u_r   <= p0_u_r;
    p2_a_r   <= 55'(mean_r * p1_y_r);
    p2_f_r   <= {shape_r, 26'd0};
    p2_u_r   <= p1_u_r;
  end

  // Normalising shift: binary search so the larger operand drops below 2^31.
  logic [SHIFT_STAGES:0] sh_v_r;
  logic [54:0]           sh_a_r   [0:SHIFT_STAGES];
  logic [49:0]           sh_f_r   [0:SHIFT_STAGES];
  logic [54:0]           sh_big_r [0:SHIFT_STAGES];
  logic [15:0]           sh_u_r   [0:SHIFT_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_v_r[0] <= 1'b0;
    end else begin
      sh_v_r[0] <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sh_a_r[0]   <= p2_a_r;
    sh_f_r[0]   <= p2_f_r;
    sh_big_r[0] <= (p2_a_r > {5'd0, p2_f_r}) ? p2_a_r : {5'd0, p2_f_r};
    sh_u_r[0]   <= p2_u_r;
  end

  for (genvar j = 0; j < SHIFT_STAGES; j++) begin : g_shift
    localparam int S = 16 >> j;
    logic take;
    assign take = (sh_big_r[j] >> (30 + S)) != 55'd0;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sh_v_r[j+1] <= 1'b0;
      end else begin
        sh_v_r[j+1] <= sh_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      sh_a_r[j+1]   <= take ? (sh_a_r[j] >> S) : sh_a_r[j];
      sh_f_r[j+1]   <= take ? (sh_f_r[j] >> S) : sh_f_r[j];
      sh_big_r[j+1] <= take ? (sh_big_r[j] >> S) : sh_big_r[j];
      sh_u_r[j+1]   <= sh_u_r[j];
    end
  end

  // Product a*(a + 4*lambda) for the square root.
  logic [30:0] an;
  logic [30:0] fn;
  logic [31:0] af_sum;
  logic        pr_v_r;
  logic [62:0] pr_prod_r;
  root_side_t  pr_side_r;

  assign an     = sh_a_r[SHIFT_STAGES][30:0];
  assign fn     = sh_f_r[SHIFT_STAGES][30:0];
  assign af_sum = 32'(an) + 32'(fn);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_v_r <= 1'b0;
    end else begin
      pr_v_r <= sh_v_r[SHIFT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    pr_prod_r    <= 63'(an) * 63'(af_sum);
    pr_side_r.u  <= sh_u_r[SHIFT_STAGES];
    pr_side_r.a  <= an;
    pr_side_r.az <= an == 31'd0;
  end

  // Square root with its side information delayed alongside.
  logic        sq_v;
  logic [31:0] sq_root;
  root_side_t  rs_r [0:SQRT_STAGES-1];

  igt_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pr_v_r),
    .radicand  (pr_prod_r),
    .out_valid (sq_v),
    .root      (sq_root)
  );

  always_ff @(posedge clk) begin
    rs_r[0] <= pr_side_r;
    for (int k = 1; k < SQRT_STAGES; k++) begin
      rs_r[k] <= rs_r[k-1];
    end
  end

  // Numerator mean*(s - a) and denominator s + a.
  logic        nm_v_r;
  logic [55:0] nm_num_r;
  logic [32:0] nm_den_r;
  quot_side_t  nm_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_v_r <= 1'b0;
    end else begin
      nm_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    nm_num_r     <= 56'(mean_r * (sq_root - 32'(rs_r[SQRT_STAGES-1].a)));
    nm_den_r     <= 33'(sq_root) + 33'(rs_r[SQRT_STAGES-1].a);
    nm_side_r.u  <= rs_r[SQRT_STAGES-1].u;
    nm_side_r.az <= rs_r[SQRT_STAGES-1].az;
  end

  // Root division x = mean*(s - a)/(s + a).
  logic        d1_v;
  logic [31:0] d1_q;
  quot_side_t  qs_r [0:DIV_STAGES-1];

  igt_div u_div_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (nm_v_r),
    .num       (nm_num_r),
    .den       (nm_den_r),
    .out_valid (d1_v),
    .quot      (d1_q)
  );

  always_ff @(posedge clk) begin
    qs_r[0] <= nm_side_r;
    for (int k = 1; k < DIV_STAGES; k++) begin
      qs_r[k] <= qs_r[k-1];
    end
  end

  // Pick x, then form the acceptance product and mean squared.
  logic        xs_v_r, ml_v_r, cp_v_r;
  logic [23:0] xs_x_r, ml_x_r;
  logic [15:0] xs_u_r;
  logic [40:0] ml_lhs_r;
  logic [47:0] ml_msq_r;
  logic [55:0] cp_num_r;
  logic [32:0] cp_den_r;
  recip_side_t cp_side_r;
  logic        cp_ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xs_v_r <= 1'b0;
      ml_v_r <= 1'b0;
      cp_v_r <= 1'b0;
    end else begin
      xs_v_r <= d1_v;
      ml_v_r <= xs_v_r;
      cp_v_r <= ml_v_r;
    end
  end

  assign cp_ovf = {8'd0, ml_msq_r} >= {ml_x_r, 32'd0};

  always_ff @(posedge clk) begin
    xs_x_r          <= qs_r[DIV_STAGES-1].az ? mean_r : d1_q[23:0];
    xs_u_r          <= qs_r[DIV_STAGES-1].u;
    ml_lhs_r        <= 41'(xs_u_r * (25'(mean_r) + 25'(xs_x_r)));
    ml_msq_r        <= 48'(mean_r * mean_r);
    ml_x_r          <= xs_x_r;
    cp_side_r.x     <= ml_x_r;
    cp_side_r.pass  <= ml_lhs_r <= {1'b0, mean_r, 16'd0};
    cp_side_r.ovf   <= cp_ovf;
    cp_side_r.xzero <= ml_x_r == 24'd0;
    cp_num_r        <= cp_ovf ? 56'd0 : {8'd0, ml_msq_r};
    cp_den_r        <= {9'd0, ml_x_r};
  end

  // Reciprocal division mean*mean/x.
  logic        d2_v;
  logic [31:0] d2_q;
  recip_side_t cs_r [0:DIV_STAGES-1];
  recip_side_t cs_last;

  igt_div u_div_recip (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cp_v_r),
    .num       (cp_num_r),
    .den       (cp_den_r),
    .out_valid (d2_v),
    .quot      (d2_q)
  );

  always_ff @(posedge clk) begin
    cs_r[0] <= cp_side_r;
    for (int k = 1; k < DIV_STAGES; k++) begin
      cs_r[k] <= cs_r[k-1];
    end
  end

  assign cs_last = cs_r[DIV_STAGES-1];

  // Output register: choose the branch and apply saturation.
  logic        out_strobe_r;
  logic [31:0] out_sample_r;
  logic        out_recip_r;
  logic        out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cs_last.xzero) begin
      out_sample_r <= 32'd0;
    end else if (cs_last.pass) begin
      out_sample_r <= {8'd0, cs_last.x};
    end else if (cs_last.ovf) begin
      out_sample_r <= 32'hFFFF_FFFF;
    end else begin
      out_sample_r <= d2_q;
    end
    out_recip_r <= !cs_last.xzero && !cs_last.pass;
    out_sat_r   <= cs_last.xzero || (!cs_last.pass && cs_last.ovf);
  end

  assign out_strobe          = out_strobe_r;
  assign out_sample          = out_sample_r;
  assign out_took_reciprocal = out_recip_r;
  assign out_saturated       = out_sat_r;

  // Checks on the pipeline and the result.
  `ASSERT_NEXT(a_entry, clk, rst_n, start && !busy, p0_v_r, "accepted word did not enter")
  `ASSERT_IMPL(a_direct_le_mean, clk, rst_n,
               out_strobe && !out_took_reciprocal && !out_saturated,
               out_sample <= {8'd0, mean_r}, "direct branch result exceeds the mean")
  `ASSERT_IMPL(a_zero_sat, clk, rst_n, out_strobe && out_sample == 32'd0,
               out_saturated, "zero result without saturation flag")
  `ASSERT_IMPL(a_clip_recip, clk, rst_n,
               out_strobe && out_saturated && out_sample != 32'd0,
               out_took_reciprocal, "clipped result outside the reciprocal branch")

endmodule

FILE: dv/inverse_gaussian_transform_top_tb.sv
// Self-checking testbench of the inverse Gaussian transform top level.
`timescale 1ns / 100ps

module inverse_gaussian_transform_top_tb import igt_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LATENCY     = 111;
  localparam int unsigned MAX_GAP     = 12;
  localparam int unsigned N_RANDOM    = 750;

  // One predicted draw.
  typedef struct {
    logic [31:0] sample;
    logic        recip;
    logic        sat;
  } draw_t;

  // Holds the configuration, predicts each draw and checks the results.
  class draw_scoreboard;
    logic [23:0] mean_q;
    logic [23:0] shape_q;
    draw_t       pending_draws[$];
    int unsigned errors;

    function new();
      mean_q  = 24'd65536;
      shape_q = 24'd65536;
      errors  = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [23:0] data);
      if (idx == CFG_MEAN) mean_q = data;
      else if (idx == CFG_SHAPE) shape_q = data;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v    = v - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    // Candidate root x in Q16.16 for squared sample y.
    function longint unsigned candidate_root(longint unsigned y);
      longint unsigned a, f, big, s;
      int k;
      a   = longint'(mean_q) * y;
      f   = longint'(shape_q) << 26;
      big = (a > f) ? a : f;
      k   = 0;
      while (k < 63 && (big >> k) >= 64'h8000_0000) k++;
      a = a >> k;
      f = f >> k;
      if (a == 0) return longint'(mean_q);
      s = int_sqrt(a * (a + f));
      return (longint'(mean_q) * (s - a)) / (s + a);
    endfunction

    // Notes an accepted word and queues its predicted draw.
    function void note_word(logic [15:0] z, logic [15:0] u);
      longint unsigned mag, x, q, m;
      draw_t d;
      m   = longint'(mean_q);
      mag = z[15] ? longint'(17'h10000 - z) : longint'(z);
      x   = candidate_root(mag * mag);
      d.recip = 1'b0;
      d.sat   = 1'b0;
      if (x == 0) begin
        d.sample = 32'd0;
        d.sat    = 1'b1;
      end else if (longint'(u) * (m + x) <= (m << 16)) begin
        d.sample = x[31:0];
      end else begin
        q       = (m * m) / x;
        d.recip = 1'b1;
        if (q > 64'hFFFF_FFFF) begin
          q     = 64'hFFFF_FFFF;
          d.sat = 1'b1;
        end
        d.sample = q[31:0];
      end
      pending_draws.push_back(d);
    endfunction

    // Compares one result with the oldest predicted draw.
    function void check_result(logic [31:0] sample, logic recip, logic sat);
      draw_t d;
      if (pending_draws.size() == 0) begin
        $error("unexpected result: sample %h", sample);
        errors++;
        return;
      end
      d = pending_draws.pop_front();
      if (sample !== d.sample) begin
        $error("sample: expected %h, actual %h", d.sample, sample);
        errors++;
      end
      if (recip !== d.recip) begin
        $error("took_reciprocal: expected %b, actual %b", d.recip, recip);
        errors++;
      end
      if (sat !== d.sat) begin
        $error("saturated: expected %b, actual %b", d.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_normal_sample = '0;
  logic [15:0] in_uniform_sample = '0;
  logic        out_strobe;
  logic [31:0] out_sample;
  logic        out_took_reciprocal;
  logic        out_saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  draw_scoreboard sb = new();
  int unsigned    cycles = 0;

  inverse_gaussian_transform_top DUT (
    .clk, .rst_n, .start, .busy, .in_normal_sample, .in_uniform_sample,
    .out_strobe, .out_sample, .out_took_reciprocal, .out_saturated,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle count and the overall time limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[inverse_gaussian_transform_top] ERROR");
      $finish;
    end
  end

  // Every strobed result is checked at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result(out_sample, out_took_reciprocal, out_saturated);
  end

  // Writes one configuration register through its own channel.
  task automatic write_cfg(logic [7:0] idx, logic [23:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Offers one word after a random gap and notes it once it is taken.
  task automatic send_word(logic [15:0] z, logic [15:0] u);
    int unsigned gap;
    gap = $urandom_range(MAX_GAP, 0);
    if ($urandom_range(3, 0) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_normal_sample  <= z;
    in_uniform_sample <= u;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(z, u);
  endtask

  // Stops offering and waits until every predicted draw has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_draws.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Random word, mostly full range with some small magnitudes of z.
  task automatic send_random();
    logic [15:0] z;
    z = 16'($urandom());
    if ($urandom_range(3, 0) == 0) z = 16'($urandom_range(255, 0) - 128);
    send_word(z, 16'($urandom()));
  endtask

  task automatic set_both(logic [23:0] m, logic [23:0] s);
    write_cfg(CFG_MEAN, m);
    write_cfg(CFG_SHAPE, s);
  endtask

  initial begin
    int unsigned n_phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset configuration.
    send_word(16'h0000, 16'h0000);
    send_word(16'h0000, 16'hFFFF);
    send_word(16'h7FFF, 16'h0000);
    send_word(16'h7FFF, 16'hFFFF);
    send_word(16'h8000, 16'h0000);
    send_word(16'h8000, 16'hFFFF);
    send_word(16'h0001, 16'h8000);
    send_word(16'hFFFF, 16'h8000);
    send_word(16'h1000, 16'h7FFF);
    send_word(16'hF000, 16'hC000);
    drain();

    // Extreme settings, including zero mean and zero shape.
    set_both(24'd1, 24'd1);
    send_word(16'h7FFF, 16'hFFFF);
    send_word(16'h0001, 16'hFFFF);
    send_word(16'h0000, 16'h1234);
    drain();
    set_both(24'hFFFFFF, 24'hFFFFFF);
    send_word(16'h8000, 16'hFFFF);
    send_word(16'h0001, 16'h0000);
    drain();
    set_both(24'hFFFFFF, 24'd1);
    send_word(16'h7FFF, 16'hFFFF);
    send_word(16'h0010, 16'hFFFF);
    drain();
    set_both(24'd0, 24'd65536);
    send_word(16'h1000, 16'hFFFF);
    drain();
    set_both(24'd65536, 24'd0);
    send_word(16'h1000, 16'h0000);
    drain();

    // An unused register index must be ignored.
    write_cfg(8'($urandom_range(255, 2)), 24'($urandom()));

    // Random phases, each with a fresh setting.
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(3, 0))
        0: set_both(24'($urandom()), 24'($urandom()));
        1: set_both(24'($urandom_range(24'h040000, 1)),
                    24'($urandom_range(24'h040000, 1)));
        2: set_both(24'hFFFFFF, 24'($urandom()));
        default: set_both(24'($urandom()), 24'($urandom_range(255, 1)));
      endcase
      n_phase = N_RANDOM / 10;
      for (int i = 0; i < n_phase; i++) begin
        send_random();
        // Once, hold the sender until every draw is back.
        if (p == 4 && i == n_phase / 2) drain();
      end
      // One stretch without gaps in each phase.
      start <= 1'b1;
      for (int i = 0; i < 8; i++) begin
        in_normal_sample  <= 16'($urandom());
        in_uniform_sample <= 16'($urandom());
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_word(in_normal_sample, in_uniform_sample);
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("[inverse_gaussian_transform_top] OK");
    end else begin
      $display("[inverse_gaussian_transform_top] ERROR");
    end
    $finish;
  end

endmodule
